// File: hdl/hcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hcbd_pkg - shared types and constants of the chunked body decoder
// Byte classes, result and error codes, queue sizing, limit defaults.
// ---------------------------------------------------------------------------
package hcbd_pkg;

	localparam int unsigned SIZE_LINE_LIMIT_DEF = 64;
	localparam int unsigned COUNT_WIDTH_DEF     = 32;

	localparam logic [31:0] LIMIT_RESET = 32'd16777216;

	// Configuration register indexes
	localparam logic CFG_MAX_CHUNK = 1'b0;
	localparam logic CFG_MAX_BODY  = 1'b1;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	// Front-to-back queue
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QLVL_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		RK_BODY  = 2'd0,
		RK_DONE  = 2'd1,
		RK_ERROR = 2'd2
	} result_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_DIGIT   = 3'd1,
		ERR_LONG    = 3'd2,
		ERR_CHUNK   = 3'd3,
		ERR_BODY    = 3'd4,
		ERR_DATA_NL = 3'd5,
		ERR_TRAILER = 3'd6
	} error_kind_t;

	// One classified stream byte
	typedef struct packed {
		logic [7:0] data;
		logic       new_msg;
		logic       is_cr;
		logic       is_lf;
		logic       is_semi;
		logic       is_hex;
		logic [3:0] hex_val;
	} hcbd_item_t;

	typedef struct packed {
		logic              nonempty;
		logic [QLVL_W-1:0] level;
	} hcbd_qstat_t;

	typedef struct packed {
		logic [31:0] max_chunk;
		logic [31:0] max_body;
	} hcbd_limits_t;

endpackage
`default_nettype wire

// File: hdl/hcbd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hcbd_front - byte classifier and item queue
// Tags each accepted byte (CR, LF, ';', hex digit and value) and queues it.
// ---------------------------------------------------------------------------
module hcbd_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire  [7:0]           data_byte,
	input  wire                  new_message,
	input  wire                  pop,
	output hcbd_pkg::hcbd_item_t head,
	output hcbd_pkg::hcbd_qstat_t qstat
);
	import hcbd_pkg::*;

	hcbd_item_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QLVL_W-1:0] level_q;
	hcbd_item_t        cls;
	logic              push;

	always_comb begin
		cls         = '0;
		cls.data    = data_byte;
		cls.new_msg = new_message;
		cls.is_cr   = (data_byte == CH_CR);
		cls.is_lf   = (data_byte == CH_LF);
		cls.is_semi = (data_byte == CH_SEMI);
		case (data_byte) inside
			[8'h30:8'h39]: begin
				cls.is_hex  = 1'b1;
				cls.hex_val = data_byte[3:0];
			end
			[8'h41:8'h46], [8'h61:8'h66]: begin
				cls.is_hex  = 1'b1;
				cls.hex_val = 4'(data_byte[2:0] + 3'd1) + 4'd8;
			end
			default: begin
				cls.is_hex  = 1'b0;
				cls.hex_val = 4'd0;
			end
		endcase
	end

	assign in_stall       = (level_q == QLVL_W'(QDEPTH));
	assign push           = in_valid && !in_stall;
	assign head           = mem_q[rd_ptr_q];
	assign qstat.nonempty = (level_q != '0);
	assign qstat.level    = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/hcbd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hcbd_back - chunk framing state machine and result register
// Walks size lines, data, CRLFs and the last chunk; one queued byte a cycle unless a held result stalls it.
// ---------------------------------------------------------------------------
module hcbd_back #(
	parameter int unsigned SIZE_LINE_LIMIT = hcbd_pkg::SIZE_LINE_LIMIT_DEF,
	parameter int unsigned COUNT_WIDTH     = hcbd_pkg::COUNT_WIDTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  hcbd_pkg::hcbd_item_t   head,
	input  hcbd_pkg::hcbd_qstat_t  qstat,
	output logic                   pop,
	input  hcbd_pkg::hcbd_limits_t limits,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic [1:0]             result_kind,
	output logic [7:0]             body_byte,
	output logic [2:0]             error_kind,
	output logic [31:0]            consumed_count
);
	import hcbd_pkg::*;

	localparam int unsigned LEN_W = $clog2(SIZE_LINE_LIMIT + 2);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(SIZE_LINE_LIMIT + 1);

	typedef enum logic [7:0] {
		PH_SIZE    = 8'b0000_0001,
		PH_DATA    = 8'b0000_0010,
		PH_DATA_CR = 8'b0000_0100,
		PH_DATA_LF = 8'b0000_1000,
		PH_LAST_CR = 8'b0001_0000,
		PH_LAST_LF = 8'b0010_0000,
		PH_DONE    = 8'b0100_0000,
		PH_FAIL    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		error_kind_t      err;
		logic [LEN_W-1:0] len;
		logic             ext;
		logic             dig;
		logic [31:0]      acc;
	} line_st_t;

	phase_t                 phase_q, cur_phase, nxt_phase;
	line_st_t               line_q, cur_line, nxt_line, lc;
	logic                   pcr_q, cur_pcr, nxt_pcr;
	logic [31:0]            total_q, cur_total, nxt_total;
	logic [COUNT_WIDTH-1:0] seen_q, cur_seen, nxt_seen;
	logic [32:0]            total_sum;
	logic                   res_valid;
	result_kind_t           res_kind;
	error_kind_t            res_err;

	// One content byte of a size line
	function automatic line_st_t line_char(line_st_t s, logic semi, logic hex,
		logic [3:0] hv, logic [31:0] maxc);
		line_st_t    r;
		logic [35:0] v;
		r     = s;
		r.err = ERR_NONE;
		v     = {s.acc, hv};
		if (s.len >= LEN_MAX) begin
			r.err = ERR_LONG;
		end else begin
			r.len = s.len + 1'b1;
			if (!s.ext) begin
				if (semi) begin
					if (!s.dig) r.err = ERR_DIGIT;
					else r.ext = 1'b1;
				end else if (hex) begin
					if (v > {4'd0, maxc}) begin
						r.err = ERR_CHUNK;
					end else begin
						r.acc = v[31:0];
						r.dig = 1'b1;
					end
				end else begin
					r.err = ERR_DIGIT;
				end
			end
		end
		return r;
	endfunction

	assign pop = qstat.nonempty && (!out_valid || !out_stall);

	always_comb begin
		// new_message wipes the message state ahead of this byte
		if (head.new_msg) begin
			cur_phase = PH_SIZE;
			cur_line  = '0;
			cur_pcr   = 1'b0;
			cur_total = '0;
			cur_seen  = '0;
		end else begin
			cur_phase = phase_q;
			cur_line  = line_q;
			cur_pcr   = pcr_q;
			cur_total = total_q;
			cur_seen  = seen_q;
		end
		cur_line.err = ERR_NONE;

		nxt_phase = cur_phase;
		nxt_line  = cur_line;
		nxt_pcr   = cur_pcr;
		nxt_total = cur_total;
		nxt_seen  = cur_seen + 1'b1;
		total_sum = {1'b0, cur_total} + {1'b0, cur_line.acc};
		lc        = cur_line;
		res_valid = 1'b0;
		res_kind  = RK_BODY;
		res_err   = ERR_NONE;

		case (cur_phase)
			PH_SIZE: begin
				nxt_pcr = 1'b0;
				if (cur_pcr && head.is_lf) begin
					// size line complete
					if (!cur_line.dig) begin
						res_err = ERR_DIGIT;
					end else if (cur_line.acc > limits.max_chunk) begin
						res_err = ERR_CHUNK;
					end else if (cur_line.acc == '0) begin
						nxt_phase = PH_LAST_CR;
					end else if (total_sum > {1'b0, limits.max_body}) begin
						res_err = ERR_BODY;
					end else begin
						nxt_total = total_sum[31:0];
						nxt_phase = PH_DATA;
					end
				end else begin
					// a CR not followed by LF counts as line content
					if (cur_pcr) begin
						lc = line_char(cur_line, 1'b0, 1'b0, 4'd0, limits.max_chunk);
					end
					res_err = lc.err;
					if (lc.err == ERR_NONE) begin
						if (head.is_cr) begin
							nxt_pcr  = 1'b1;
							nxt_line = lc;
						end else begin
							nxt_line = line_char(lc, head.is_semi, head.is_hex,
								head.hex_val, limits.max_chunk);
							res_err  = nxt_line.err;
						end
					end
				end
			end
			PH_DATA: begin
				res_valid    = 1'b1;
				res_kind     = RK_BODY;
				nxt_line.acc = cur_line.acc - 1'b1;
				if (cur_line.acc == 32'd1) begin
					nxt_phase = PH_DATA_CR;
				end
			end
			PH_DATA_CR: begin
				if (head.is_cr) nxt_phase = PH_DATA_LF;
				else res_err = ERR_DATA_NL;
			end
			PH_DATA_LF: begin
				if (head.is_lf) begin
					nxt_phase = PH_SIZE;
					nxt_line  = '0;
					nxt_pcr   = 1'b0;
				end else begin
					res_err = ERR_DATA_NL;
				end
			end
			PH_LAST_CR: begin
				if (head.is_cr) nxt_phase = PH_LAST_LF;
				else res_err = ERR_TRAILER;
			end
			PH_LAST_LF: begin
				if (head.is_lf) begin
					nxt_phase = PH_DONE;
					res_valid = 1'b1;
					res_kind  = RK_DONE;
				end else begin
					res_err = ERR_TRAILER;
				end
			end
			default: begin
				// done or failed: silent until the next message
				nxt_seen = cur_seen;
			end
		endcase

		if (res_err != ERR_NONE) begin
			nxt_phase = PH_FAIL;
			res_valid = 1'b1;
			res_kind  = RK_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SIZE;
			line_q    <= '0;
			pcr_q     <= 1'b0;
			total_q   <= '0;
			seen_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				phase_q   <= nxt_phase;
				line_q    <= nxt_line;
				pcr_q     <= nxt_pcr;
				total_q   <= nxt_total;
				seen_q    <= nxt_seen;
				out_valid <= res_valid;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			result_kind    <= res_kind;
			body_byte      <= (res_kind == RK_BODY) ? head.data : 8'd0;
			error_kind     <= res_err;
			consumed_count <= (res_kind == RK_DONE) ? 32'(nxt_seen) : 32'd0;
		end
	end

endmodule
`default_nettype wire

// File: hdl/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// http_chunked_body_decoder - HTTP/1.1 chunked transfer body decoder
// Strips chunk framing from a raw byte stream, passes body bytes on, and
// reports completion with the byte count, or the first framing error.
// ---------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | data_byte, new_message
//  out     | out_valid / out_stall | result_kind, body_byte, error_kind,
//          |                      | consumed_count
//  cfg     | cfg_we               | cfg_index, cfg_data
//
//  One byte per cycle sustained while no held result stalls the output:
//  the back end handles one queued byte each cycle, so every input transfer
//  can be followed by another. Each byte is written into the queue, then
//  the framing state machine loads the output register from the queue head.
//  The four-entry queue absorbs output stalls; in_stall rises only when it
//  is full. Reset clears the queue, the state and the output valid, and sets
//  both limits to 16 MiB; there is no clearing pass.
//
module http_chunked_body_decoder #(
	parameter int unsigned SIZE_LINE_LIMIT = hcbd_pkg::SIZE_LINE_LIMIT_DEF,
	parameter int unsigned COUNT_WIDTH     = hcbd_pkg::COUNT_WIDTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// input bytes
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  data_byte,
	input  wire         new_message,
	// results
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  body_byte,
	output logic [2:0]  error_kind,
	output logic [31:0] consumed_count,
	// configuration
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [31:0] cfg_data
);
	import hcbd_pkg::*;

	hcbd_limits_t limits_q;
	hcbd_item_t   head;
	hcbd_qstat_t  qstat;
	logic         pop;

	// Limit registers; written on any edge with cfg_we high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.max_chunk <= LIMIT_RESET;
			limits_q.max_body  <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_CHUNK: limits_q.max_chunk <= cfg_data;
				CFG_MAX_BODY:  limits_q.max_body  <= cfg_data;
				default:       limits_q <= limits_q;
			endcase
		end
	end

	// Front: classify each byte and queue it
	hcbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.new_message (new_message),
		.pop         (pop),
		.head        (head),
		.qstat       (qstat)
	);

	// Back: framing state machine and result register
	hcbd_back #(
		.SIZE_LINE_LIMIT (SIZE_LINE_LIMIT),
		.COUNT_WIDTH     (COUNT_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.qstat          (qstat),
		.pop            (pop),
		.limits         (limits_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.body_byte      (body_byte),
		.error_kind     (error_kind),
		.consumed_count (consumed_count)
	);

	// Queue never overfills
	a_q_level: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.level <= QLVL_W'(QDEPTH))
		else $error("queue level beyond depth");

	// Input is held off only by a full queue
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (qstat.level == QLVL_W'(QDEPTH)))
		else $error("input stalled with room in queue");

	// An error result carries a code and no body byte or count
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == 2'(RK_ERROR)) |->
		(error_kind != 3'(ERR_NONE) && body_byte == 8'd0 && consumed_count == 32'd0))
		else $error("malformed error result");

	// Body and completion results carry no error code
	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind != 2'(RK_ERROR)) |-> (error_kind == 3'(ERR_NONE)))
		else $error("error code on a non-error result");

endmodule
`default_nettype wire

// File: test/http_chunked_body_decoder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_tb - self-checking bench for the chunked decoder
// Feeds chunked byte streams through the decoder and predicts every body
// byte, completion and framing error in a bit-true model of the framing
// rules. Each result is checked field by field against the oldest prediction.
// Directed cases cover framing faults and limits; random traffic runs under
// several limit settings and handshake idling mixes.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_tb;
	import hcbd_pkg::*;

	localparam int LONG_HOLD   = 300;  // receiver hold-off, in cycles
	localparam int PHASE_ITEMS = 350;  // decoded input bytes per random phase
	localparam int SETTLE      = 10;   // cycles to let the decoder empty
	localparam int MAX_REPORTS = 50;

	// Parser position within one message
	typedef enum logic [2:0] {
		P_SIZE,
		P_DATA,
		P_DATA_CR,
		P_DATA_LF,
		P_LAST_CR,
		P_LAST_LF,
		P_DONE,
		P_FAIL
	} parse_phase_t;

	typedef struct {
		result_kind_t kind;
		logic [7:0]   body;
		error_kind_t  err;
		logic [31:0]  count;
	} decode_event_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        new_message;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  result_kind;
	logic [7:0]  body_byte;
	logic [2:0]  error_kind;
	logic [31:0] consumed_count;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;

	http_chunked_body_decoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.new_message    (new_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.body_byte      (body_byte),
		.error_kind     (error_kind),
		.consumed_count (consumed_count),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// ------------------------------------------------------------------
	// Decoder model state; reset values are the declaration values since
	// reset is applied once at time zero.
	// ------------------------------------------------------------------
	parse_phase_t parse_ph    = P_SIZE;
	logic [31:0]  chunk_left  = '0;  // size while parsing, then bytes left
	logic         digit_seen  = 1'b0;
	logic         in_ext      = 1'b0;
	logic         cr_held     = 1'b0;  // CR seen, waiting to see if LF follows
	int unsigned  line_len    = 0;
	logic [31:0]  body_total  = '0;
	logic [31:0]  msg_bytes   = '0;    // wraps at 32 bits
	logic [31:0]  lim_chunk   = LIMIT_RESET;
	logic [31:0]  lim_body    = LIMIT_RESET;

	decode_event_t decode_events[$];

	// stimulus control and statistics
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic long_hold      = 1'b0;
	event hold_go;
	logic [8:0] stream[$];  // {new_message, byte}
	int   live_items     = 0;
	int   fail_count     = 0;
	int   body_seen      = 0;
	int   done_seen      = 0;
	int   fault_seen     = 0;
	int   stall_cycles   = 0;
	int   cfg_writes     = 0;

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------
	function automatic void start_size_line();
		parse_ph   = P_SIZE;
		chunk_left = '0;
		digit_seen = 1'b0;
		in_ext     = 1'b0;
		cr_held    = 1'b0;
		line_len   = 0;
	endfunction

	// Append one predicted result
	function automatic void add_event(input result_kind_t k, input logic [7:0] b,
			input error_kind_t e, input logic [31:0] n);
		decode_event_t ev;
		ev = '{k, b, e, n};
		decode_events = {decode_events, ev};
	endfunction

	// One content byte of a size line
	function automatic error_kind_t size_line_byte(input logic [7:0] c);
		logic [3:0]  nibble;
		logic [35:0] grown;
		if (line_len >= SIZE_LINE_LIMIT_DEF + 1)
			return ERR_LONG;
		line_len++;
		if (in_ext)
			return ERR_NONE;
		if (c == CH_SEMI) begin
			if (!digit_seen)
				return ERR_DIGIT;
			in_ext = 1'b1;
			return ERR_NONE;
		end
		if (c >= "0" && c <= "9")
			nibble = 4'(c - "0");
		else if (c >= "a" && c <= "f")
			nibble = 4'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F")
			nibble = 4'(c - "A" + 8'd10);
		else
			return ERR_DIGIT;
		grown = {chunk_left, 4'h0} + {32'd0, nibble};
		// over-limit digit fails at once, so the size never exceeds the limit
		if (grown > {4'h0, lim_chunk})
			return ERR_CHUNK;
		chunk_left = grown[31:0];
		digit_seen = 1'b1;
		return ERR_NONE;
	endfunction

	// CR LF closing a size line
	function automatic error_kind_t size_line_done();
		logic [32:0] total;
		cr_held = 1'b0;
		if (!digit_seen)
			return ERR_DIGIT;
		if (chunk_left > lim_chunk)
			return ERR_CHUNK;
		if (chunk_left == 0) begin
			parse_ph = P_LAST_CR;
			return ERR_NONE;
		end
		total = {1'b0, body_total} + {1'b0, chunk_left};
		if (total > {1'b0, lim_body})
			return ERR_BODY;
		body_total = total[31:0];
		parse_ph   = P_DATA;
		return ERR_NONE;
	endfunction

	// Advance the model by one accepted byte and queue what it must produce
	function automatic void decode_byte(input logic [7:0] c, input logic nm);
		error_kind_t fault;
		fault = ERR_NONE;
		if (nm) begin
			start_size_line();
			body_total = '0;
			msg_bytes  = '0;
		end
		// finished or failed message: silent until restarted
		if (parse_ph == P_DONE || parse_ph == P_FAIL)
			return;
		live_items++;
		msg_bytes++;
		case (parse_ph)
			P_SIZE: begin
				if (cr_held) begin
					cr_held = 1'b0;
					if (c == CH_LF) begin
						fault = size_line_done();
					end else begin
						// a CR not followed by LF counts as line content
						fault = size_line_byte(CH_CR);
						if (fault == ERR_NONE) begin
							if (c == CH_CR)
								cr_held = 1'b1;
							else
								fault = size_line_byte(c);
						end
					end
				end else if (c == CH_CR) begin
					cr_held = 1'b1;
				end else begin
					fault = size_line_byte(c);
				end
			end
			P_DATA: begin
				add_event(RK_BODY, c, ERR_NONE, 32'd0);
				chunk_left--;
				if (chunk_left == 0)
					parse_ph = P_DATA_CR;
			end
			P_DATA_CR: begin
				if (c == CH_CR)
					parse_ph = P_DATA_LF;
				else
					fault = ERR_DATA_NL;
			end
			P_DATA_LF: begin
				if (c == CH_LF)
					start_size_line();
				else
					fault = ERR_DATA_NL;
			end
			P_LAST_CR: begin
				if (c == CH_CR)
					parse_ph = P_LAST_LF;
				else
					fault = ERR_TRAILER;
			end
			default: begin
				if (c == CH_LF) begin
					parse_ph = P_DONE;
					add_event(RK_DONE, 8'd0, ERR_NONE, msg_bytes);
				end else begin
					fault = ERR_TRAILER;
				end
			end
		endcase
		if (fault != ERR_NONE) begin
			parse_ph = P_FAIL;
			add_event(RK_ERROR, 8'd0, fault, 32'd0);
		end
	endfunction

	// ------------------------------------------------------------------
	// Clock, receiver stall and long hold-off
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= long_hold || ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// hold-off is counted here so the sender keeps offering bytes meanwhile
	initial begin
		forever begin
			@(hold_go);
			long_hold <= 1'b1;
			repeat (LONG_HOLD) @(negedge clk);
			long_hold <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Input monitor: every accepted transfer advances the model.
	// Sampled at the rising edge, before the decoder's own updates land.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			decode_byte(data_byte, new_message);
		if (arst_n && in_valid && in_stall)
			stall_cycles++;
	end

	function automatic void flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
	endfunction

	// Result checker: compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		decode_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (decode_events.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: result with none expected, expected nothing, actual kind %0d",
						$time, result_kind);
			end else begin
				want = decode_events.pop_front();
				case (want.kind)
					RK_BODY: body_seen++;
					RK_DONE: done_seen++;
					default: fault_seen++;
				endcase
				if (result_kind !== want.kind)
					flag_mismatch("result_kind", 32'(want.kind), 32'(result_kind));
				if (body_byte !== want.body)
					flag_mismatch("body_byte", 32'(want.body), 32'(body_byte));
				if (error_kind !== want.err)
					flag_mismatch("error_kind", 32'(want.err), 32'(error_kind));
				if (consumed_count !== want.count)
					flag_mismatch("consumed_count", want.count, consumed_count);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void put_entry(input logic nm, input logic [7:0] b);
		logic [8:0] ent;
		ent    = {nm, b};
		stream = {stream, ent};
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		put_entry(1'b0, b);
	endfunction

	function automatic void put_text(input string s);
		foreach (s[i])
			put_byte(s[i]);
	endfunction

	function automatic void put_crlf();
		put_byte(CH_CR);
		put_byte(CH_LF);
	endfunction

	// Size line in hex; "fancy" may add leading zeros, mixed case and an extension
	function automatic void put_size_line(input logic [31:0] size, input bit fancy);
		string      digits;
		int         ext_len;
		logic [7:0] ch;
		digits = $sformatf("%0h", size);
		if (fancy && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) put_byte("0");
		foreach (digits[i]) begin
			ch = digits[i];
			if (fancy && ch >= "a" && $urandom_range(0, 1) == 1)
				ch = ch - 8'h20;
			put_byte(ch);
		end
		if (fancy && $urandom_range(0, 3) == 0) begin
			put_byte(CH_SEMI);
			// now and then long enough to cross the line limit
			ext_len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 70) :
				$urandom_range(0, 12);
			repeat (ext_len) begin
				ch = 8'($urandom_range(0, 255));
				if (ch == CH_CR)
					ch = CH_LF;
				put_byte(ch);
			end
		end
		put_crlf();
	endfunction

	function automatic void put_chunk(input int len);
		put_size_line(len, 1'b0);
		repeat (len) put_byte(8'($urandom_range(0, 255)));
		put_crlf();
	endfunction

	// Mostly well-formed message with random chunks; occasionally a trailer line
	function automatic void build_message();
		int len;
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 19))
				0:       len = $urandom_range(81, 300);
				1, 2, 3,
				4, 5:    len = $urandom_range(17, 80);
				default: len = $urandom_range(1, 16);
			endcase
			put_size_line(len, 1'b1);
			repeat (len) put_byte(8'($urandom_range(0, 255)));
			put_crlf();
		end
		put_size_line(0, 1'b1);
		if ($urandom_range(0, 9) == 0) begin
			put_text("X-T: 1");
			put_crlf();
		end
		put_crlf();
	endfunction

	// One input transfer, with optional idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic nm);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		data_byte   <= b;
		new_message <= nm;
		do @(posedge clk); while (in_stall);
	endtask

	// Send the staged bytes; a fresh stream starts a new message
	task automatic send_stream(input bit fresh = 1'b1);
		foreach (stream[i])
			send_byte(stream[i][7:0], stream[i][8] | (fresh && i == 0));
		stream.delete();
	endtask

	// Stop sending and wait for every predicted result, then let the
	// decoder run dry on bytes that produce nothing
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (decode_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register write; only called with the decoder idle
	task automatic write_limit(input logic idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_CHUNK)
			lim_chunk = value;
		else
			lim_body = value;
		cfg_writes++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Framing rules at reset limits, well-formed and faulty cases
	task automatic test_directed_framing();
		// last chunk only
		put_text("0"); put_crlf(); put_crlf(); send_stream();
		// chunk with extension
		put_text("2;e"); put_crlf(); put_text("hi"); put_crlf();
		put_text("0"); put_crlf(); put_crlf(); send_stream();
		// ';' ahead of any digit
		put_text(";"); send_stream();
		// non-hex byte
		put_text("g"); send_stream();
		// bare CR is content, so a bad digit
		put_text("1"); put_byte(CH_CR); put_text("X"); send_stream();
		// size line with no digit
		put_crlf(); send_stream();
		// data not closed by CR LF
		put_text("1"); put_crlf(); put_text("ab"); send_stream();
		// trailer line after the last chunk
		put_text("0"); put_crlf(); put_text("X"); send_stream();
		// bytes after completion are dropped
		put_text("0"); put_crlf(); put_crlf(); put_text("Q"); send_stream();
		// restart in the middle of chunk data
		put_text("3"); put_crlf(); put_text("a"); send_stream();
		// size line of exactly 65 content bytes, lone LF in the extension
		put_text("1;"); put_byte(CH_LF); repeat (62) put_byte("e"); put_crlf();
		put_text("Z"); put_crlf(); put_text("0"); put_crlf(); put_crlf(); send_stream();
		// one content byte over
		put_text("1;"); repeat (64) put_byte("e"); send_stream();
		// chunk at the limit, then one over
		put_text("1000000"); put_crlf(); send_stream();
		put_text("1000001"); send_stream();
		wait_idle();
	endtask

	// Long receiver hold-off fills the decoder; then a sender pause mid-chunk
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		put_size_line(64, 1'b0);
		repeat (40) put_byte(8'($urandom_range(0, 255)));
		-> hold_go;
		send_stream();
		wait_idle();
		repeat (24) put_byte(8'($urandom_range(0, 255)));
		put_crlf(); put_text("0"); put_crlf(); put_crlf();
		send_stream(1'b0);
		wait_idle();
	endtask

	// Both registers at zero, at all ones, and a tight chunk and body limit
	task automatic test_limit_extremes();
		write_limit(CFG_MAX_CHUNK, 32'd0);
		write_limit(CFG_MAX_BODY, 32'd0);
		put_text("1"); send_stream();
		put_text("00"); put_crlf(); put_crlf(); send_stream();
		wait_idle();

		write_limit(CFG_MAX_CHUNK, '1);
		write_limit(CFG_MAX_BODY, '1);
		put_text("fedcBA98"); put_crlf(); put_text("x"); send_stream();
		// ninth digit cannot fit below the all-ones limit
		put_text("100000000"); send_stream();
		wait_idle();

		write_limit(CFG_MAX_CHUNK, 32'd16);
		write_limit(CFG_MAX_BODY, 32'd40);
		// body lands exactly on the limit
		put_chunk(16); put_chunk(16); put_chunk(8);
		put_text("0"); put_crlf(); put_crlf(); send_stream();
		put_text("11"); send_stream();
		// third chunk pushes the body one past the limit
		put_chunk(16); put_chunk(16); put_size_line(9, 1'b0); send_stream();
		wait_idle();
	endtask

	// Random messages, mostly well formed, some damaged, some plain noise
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input logic [31:0] chunk_lim, input logic [31:0] body_lim);
		int goal;
		int cut;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		write_limit(CFG_MAX_CHUNK, chunk_lim);
		write_limit(CFG_MAX_BODY, body_lim);
		goal = live_items + PHASE_ITEMS;
		while (live_items < goal) begin
			build_message();
			case ($urandom_range(0, 19))
				0, 1, 2: stream[$urandom_range(0, stream.size() - 1)][7:0] =
					8'($urandom_range(0, 255));
				3: begin
					cut    = $urandom_range(1, stream.size() - 1);
					stream = stream[0:cut-1];
				end
				4: begin
					// noise with random restarts
					stream.delete();
					repeat ($urandom_range(1, 12))
						put_entry(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				end
				5: begin
					// wide size line: every hex digit in either case
					stream.delete();
					put_size_line($urandom, 1'b1);
					repeat (3) put_byte(8'($urandom_range(0, 255)));
				end
				default: ;
			endcase
			send_stream();
		end
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		data_byte   = 8'd0;
		new_message = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_MAX_CHUNK;
		cfg_data    = 32'd0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_framing();
		test_backpressure();
		test_limit_extremes();
		// idling mixes: none, sender, receiver, both
		test_random_traffic(0, 0, LIMIT_RESET, LIMIT_RESET);
		test_random_traffic(63, 0, $urandom_range(8, 48), $urandom_range(16, 256));
		test_random_traffic(0, 63, '1, $urandom_range(64, 600));
		test_random_traffic(30, 30, $urandom_range(1, 300), '1);

		$display("summary: %0d decoded input bytes, %0d body bytes, %0d messages done, %0d faults",
			live_items, body_seen, done_seen, fault_seen);
		$display("summary: %0d input stall cycles, %0d register writes", stall_cycles,
			cfg_writes);
		if (fail_count == 0)
			$display("http_chunked_body_decoder_tb: clean");
		else
			$display("http_chunked_body_decoder_tb: errors");
		$finish;
	end

	// watchdog
	initial begin
		#3ms;
		$display("http_chunked_body_decoder_tb: errors");
		$finish;
	end

endmodule
